// ===== hdl/bmhq_pkg.sv =====
// Shared constants, payload types and status codes for the binary max-heap queue.
`default_nettype none

package bmhq_pkg;

  // Storage geometry.
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SLOT_W  = $clog2(DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 11;
  localparam int LIMIT_W = 11;

  // Reset value of the capacity limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  // Operation codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_value;
    status_t                 status;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/bmhq_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/bmhq_ctrl.sv =====
// Heap sequencer: sift-up for inserts and sift-down for removes over the heap RAM.
`default_nettype none

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire in_item_t            in_item,
  output logic                     busy,
  input  wire logic [LIMIT_W-1:0]  cfg_limit,
  output logic                     out_valid,
  output out_item_t                out_item,
  output logic                     ram_wr_en,
  output logic [ADDR_W-1:0]        ram_wr_addr,
  output logic [KEY_W-1:0]         ram_wr_data,
  output logic [ADDR_W-1:0]        ram_rd_addr_a,
  output logic [ADDR_W-1:0]        ram_rd_addr_b,
  input  wire logic [KEY_W-1:0]    ram_rd_data_a,
  input  wire logic [KEY_W-1:0]    ram_rd_data_b
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UP,
    S_LOAD,
    S_DOWN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]       pos_r, pos_nxt;
  logic [SLOT_W-1:0]       last_r, last_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] top_r, top_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic [SLOT_W:0]         child_a;
  logic [SLOT_W:0]         child_b;
  logic [SLOT_W:0]         cnt_inc;
  logic                    has_a;
  logic                    has_b;
  logic                    pick_b;
  logic signed [KEY_W-1:0] val_a;
  logic signed [KEY_W-1:0] val_b;
  logic signed [KEY_W-1:0] child_val;
  logic [SLOT_W-1:0]       child_slot;
  logic                    is_full;

  // Heap slots count from 1; slot s lives at RAM address s-1.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W:0] s);
    logic [SLOT_W:0] d;
    d = s - 1'b1;
    return d[ADDR_W-1:0];
  endfunction

  // Child slots of the current position and the larger-child selection.
  assign child_a    = {pos_r, 1'b0};
  assign child_b    = child_a + 1'b1;
  assign has_a      = child_a <= {1'b0, last_r};
  assign has_b      = child_b <= {1'b0, last_r};
  assign val_a      = $signed(ram_rd_data_a);
  assign val_b      = $signed(ram_rd_data_b);
  assign pick_b     = has_b && (val_a < val_b);
  assign child_val  = pick_b ? val_b : val_a;
  assign child_slot = pick_b ? child_b[SLOT_W-1:0] : child_a[SLOT_W-1:0];
  assign cnt_inc    = {1'b0, cnt_r} + 1'b1;

  // Full when the count has reached the limit or the physical depth.
  assign is_full = (32'(cnt_r) >= 32'(cfg_limit)) || (32'(cnt_r) >= DEPTH);

  // Next-state and RAM access logic.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    key_nxt       = key_r;
    top_nxt       = top_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = slot_addr({1'b0, pos_r});
    ram_wr_data   = key_r;
    ram_rd_addr_a = '0;
    ram_rd_addr_b = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.mode == MODE_INSERT) begin
            if (is_full) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{removed_value: '0, status: ST_FULL,
                                entry_count: CNT_W'(cnt_r), is_empty: cnt_r == '0};
            end else begin
              // New key goes into the slot past the end; fetch its parent.
              cnt_nxt       = cnt_inc[SLOT_W-1:0];
              pos_nxt       = cnt_inc[SLOT_W-1:0];
              key_nxt       = in_item.value;
              ram_rd_addr_a = slot_addr(cnt_inc >> 1);
              state_nxt     = S_UP;
            end
          end else begin
            if (cnt_r == '0) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{removed_value: '0, status: ST_EMPTY,
                                entry_count: CNT_W'(cnt_r), is_empty: 1'b1};
            end else begin
              // Fetch the root and the last entry, which becomes the sifted key.
              cnt_nxt       = cnt_r - 1'b1;
              last_nxt      = cnt_r - 1'b1;
              pos_nxt       = SLOT_W'(1);
              ram_rd_addr_a = slot_addr((SLOT_W+1)'(1));
              ram_rd_addr_b = slot_addr({1'b0, cnt_r});
              state_nxt     = S_LOAD;
            end
          end
        end
      end

      S_UP: begin
        // Parent data is on port A; move it down while it is smaller than the key.
        ram_wr_en = 1'b1;
        if ((pos_r != SLOT_W'(1)) && (val_a < key_r)) begin
          ram_wr_data   = ram_rd_data_a;
          pos_nxt       = pos_r >> 1;
          ram_rd_addr_a = slot_addr({1'b0, pos_r} >> 2);
        end else begin
          ram_wr_data   = key_r;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{removed_value: '0, status: ST_DONE,
                            entry_count: CNT_W'(cnt_r), is_empty: cnt_r == '0};
          state_nxt     = S_IDLE;
        end
      end

      S_LOAD: begin
        // Latch the old root and the key, then fetch both children of the root.
        top_nxt       = val_a;
        key_nxt       = val_b;
        ram_rd_addr_a = slot_addr(child_a);
        ram_rd_addr_b = slot_addr(child_b);
        state_nxt     = S_DOWN;
      end

      S_DOWN: begin
        // Children data is on ports A and B; pull the larger one up if it beats the key.
        ram_wr_en = 1'b1;
        if (has_a && (key_r < child_val)) begin
          ram_wr_data   = child_val;
          pos_nxt       = child_slot;
          ram_rd_addr_a = slot_addr({child_slot, 1'b0});
          ram_rd_addr_b = slot_addr({child_slot, 1'b1});
        end else begin
          ram_wr_data   = key_r;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{removed_value: top_r, status: ST_DONE,
                            entry_count: CNT_W'(cnt_r), is_empty: cnt_r == '0};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, working registers and the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      key_r       <= key_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hdl/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue: limit register, sequencer and heap RAM.
//
// Usage: drive in_item and raise start; a beat is taken at a clock edge where start is
// high and busy is low. mode selects insert or remove-maximum. Every accepted beat
// produces exactly one result beat on out_item, marked by out_valid for one cycle; the
// receiver cannot hold it off. A full insert or an empty remove is rejected with a
// status code, and its result follows in the cycle after acceptance without raising
// busy. An insert walks up one heap level per cycle. A remove first fetches the root
// and the last entry, then walks down one level per cycle. The walk is set by the
// single heap RAM: each level needs one registered read (two ports serve both children)
// and one write. The next beat may be accepted on the cycle the result is shown.
// The capacity limit is written over the cfg channel while the queue is idle; cfg_ready
// is low while busy. Synchronous reset empties the queue and sets the limit to 1024;
// the heap RAM is not cleared, as data read from slots past the count is never used.
`default_nettype none

module binary_max_heap_queue
  import bmhq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  output out_item_t               out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] limit_r;
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [KEY_W-1:0]   ram_wr_data;
  logic [ADDR_W-1:0]  ram_rd_addr_a;
  logic [ADDR_W-1:0]  ram_rd_addr_b;
  logic [KEY_W-1:0]   ram_rd_data_a;
  logic [KEY_W-1:0]   ram_rd_data_b;

  // Capacity limit register, written by a cfg beat.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // Heap sequencer.
  bmhq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_item       (in_item),
    .busy          (busy),
    .cfg_limit     (limit_r),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_addr_a (ram_rd_addr_a),
    .ram_rd_addr_b (ram_rd_addr_b),
    .ram_rd_data_a (ram_rd_data_a),
    .ram_rd_data_b (ram_rd_data_b)
  );

  // Heap storage.
  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_addr_a (ram_rd_addr_a),
    .rd_addr_b (ram_rd_addr_b),
    .rd_data_a (ram_rd_data_a),
    .rd_data_b (ram_rd_data_b)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the binary max-heap queue, with a heap predictor and random traffic.
`default_nettype none

module tb;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 16;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;

  // Pending operations for the driver and predicted results for the monitor.
  in_item_t             pending_ops[$];
  out_item_t            predicted_results[$];
  int                   ops_queued;
  int                   results_seen;
  int                   error_count;
  int                   idle_pct;
  int                   cycle_count;

  // Predictor state: heap slots numbered from 1, entry count and capacity limit.
  logic signed [KEY_W-1:0] heap_model [1:DEPTH];
  int unsigned             model_count;
  logic [LIMIT_W-1:0]      model_limit;

  binary_max_heap_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one operation to the predicted heap and returns the result it should give.
  function automatic out_item_t heap_apply(in_item_t op);
    out_item_t               res;
    int unsigned             cap;
    int unsigned             pos;
    int unsigned             child;
    logic signed [KEY_W-1:0] key;
    cap = (model_limit > DEPTH) ? DEPTH : model_limit;
    res.removed_value = '0;
    res.status = ST_DONE;
    if (op.mode == MODE_INSERT) begin
      if (model_count >= cap) begin
        res.status = ST_FULL;
      end else begin
        // Sift up: parents move down only while strictly smaller than the new key.
        model_count++;
        pos = model_count;
        key = op.value;
        while (pos > 1 && heap_model[pos / 2] < key) begin
          heap_model[pos] = heap_model[pos / 2];
          pos = pos / 2;
        end
        heap_model[pos] = key;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Take the root, then sift the last entry down from the root toward the larger child.
      res.removed_value = heap_model[1];
      key = heap_model[model_count];
      model_count--;
      pos = 1;
      while (2 * pos <= model_count) begin
        child = 2 * pos;
        if (child < model_count && heap_model[child] < heap_model[child + 1]) begin
          child++;
        end
        if (!(key < heap_model[child])) break;
        heap_model[pos] = heap_model[child];
        pos = child;
      end
      heap_model[pos] = key;
    end
    res.entry_count = CNT_W'(model_count);
    res.is_empty = (model_count == 0);
    return res;
  endfunction

  // Keys lean toward duplicates and the signed extremes.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(8)) - KEY_W'(4);
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(logic mode, logic signed [KEY_W-1:0] key);
    in_item_t op;
    op.mode = mode;
    op.value = key;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  task automatic queue_insert(logic signed [KEY_W-1:0] key);
    queue_op(MODE_INSERT, key);
  endtask

  task automatic queue_remove();
    queue_op(MODE_REMOVE, $urandom());
  endtask

  // Blocks until every queued operation has produced its result, then lets the block settle.
  task automatic wait_drained();
    do @(posedge clk); while (results_seen != ops_queued);
    repeat (4) @(posedge clk);
  endtask

  // Writes the capacity limit over the cfg channel; only called while the queue is idle.
  task automatic write_limit(logic [LIMIT_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data <= LIMIT_W'($urandom());
    model_limit = limit;
  endtask

  task automatic random_mix(int count, int insert_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < insert_pct) queue_insert(pick_key());
      else queue_remove();
    end
  endtask

  // Driver: records each accepted beat with the predictor, then presents the next one.
  always @(posedge clk) begin
    if (start && !busy) begin
      predicted_results.push_back(heap_apply(in_item));
    end
    if (!start || !busy) begin
      if (rst_n && pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= pending_ops.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        $error("result with no operation pending: removed_value %0d, status %0d",
               out_item.removed_value, out_item.status);
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        results_seen++;
        if (out_item.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d",
                 want.removed_value, out_item.removed_value);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_item.entry_count);
          error_count++;
        end
        if (out_item.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_item.is_empty);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and run control.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    ops_queued = 0;
    results_seen = 0;
    error_count = 0;
    idle_pct = 36;
    model_count = 0;
    model_limit = LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty remove, key extremes, equal keys, drain past empty.
    queue_remove();
    queue_insert(32'h7FFF_FFFF);
    queue_insert(32'h8000_0000);
    queue_insert(32'h0000_0000);
    queue_insert(32'hFFFF_FFFF);
    queue_insert(32'h0000_0001);
    queue_insert(32'sd5);
    queue_insert(32'sd5);
    queue_insert(32'sd7);
    queue_insert(32'sd5);
    queue_insert(32'h8000_0000);
    repeat (11) queue_remove();
    wait_drained();

    // Capacity of one entry, then zero: every insert past the limit is refused.
    write_limit(LIMIT_W'(1));
    queue_insert(32'sd9);
    queue_insert(32'sd10);
    queue_remove();
    queue_remove();
    wait_drained();
    write_limit(LIMIT_W'(0));
    queue_insert(pick_key());
    queue_remove();
    wait_drained();

    // Limit lowered below the current count: entries stay, inserts refused until below.
    write_limit(LIMIT_W'(8));
    repeat (8) queue_insert(pick_key());
    wait_drained();
    write_limit(LIMIT_W'(3));
    queue_insert(pick_key());
    repeat (6) queue_remove();
    queue_insert(pick_key());
    queue_insert(pick_key());
    wait_drained();

    // Largest register value saturates to the full depth, so inserts are not refused here.
    write_limit(LIMIT_W'(2047));
    random_mix(40, 70);
    wait_drained();

    // Random traffic over several limits.
    write_limit(LIMIT_W'(16));
    random_mix(100, 60);
    wait_drained();
    write_limit(LIMIT_W'(5));
    random_mix(60, 50);
    wait_drained();

    // A long stretch with the sender never idle.
    idle_pct = 0;
    write_limit(LIMIT_RESET);
    random_mix(100, 55);
    wait_drained();
    idle_pct = 36;

    for (int seg = 0; seg < 4; seg++) begin
      write_limit(LIMIT_W'($urandom_range(1, 40)));
      random_mix(40, $urandom_range(35, 65));
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bmhq_pkg.sv
hdl/bmhq_ram.sv
hdl/bmhq_ctrl.sv
hdl/binary_max_heap_queue.sv
tb/tb.sv
